### rtl/ddwr_pkg.sv
`default_nettype none
package ddwr_pkg;

	localparam int VEL_W   = 16;
	localparam int CIRC_W  = 22;
	localparam int TRK_W   = 12;
	localparam int MAX_W   = 10;
	localparam int LIM_W   = MAX_W + 8;
	localparam int NUM_W   = 40;
	localparam int SUM_W   = NUM_W + 1;
	localparam int MIX_W   = NUM_W + 3;
	localparam int OUT_W   = 19;
	localparam int SCL_N   = LIM_W;
	localparam int CIDX_W  = 2;

	localparam logic [23:0] XY_GAIN = 24'd15360000;

	localparam logic [CIDX_W-1:0] CFG_CIRC  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_TRACK = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_MAX   = 2'd2;

	typedef struct packed {
		logic sx;
		logic sy;
		logic st;
		logic lat;
		logic yaw;
	} flg_t;

	typedef struct packed {
		logic [NUM_W-1:0] ax;
		logic [NUM_W-1:0] ay;
		logic [NUM_W-1:0] at;
		flg_t             f;
	} comp_t;

	function automatic logic [VEL_W-1:0] mag16(input logic [VEL_W-1:0] v);
		return v[VEL_W-1] ? VEL_W'(~v + 1'b1) : v;
	endfunction

	// one restoring step: remainder in top bits, shifted numerator/quotient below
	function automatic logic [CIRC_W+NUM_W-1:0] div_step(input logic [CIRC_W-1:0] rem,
			input logic [NUM_W-1:0] nq, input logic [CIRC_W-1:0] d);
		logic [CIRC_W:0] t;
		logic [CIRC_W:0] diff;
		logic            qb;
		t    = {rem, nq[NUM_W-1]};
		diff = t - {1'b0, d};
		qb   = (t >= {1'b0, d});
		return {qb ? diff[CIRC_W-1:0] : t[CIRC_W-1:0], nq[NUM_W-2:0], qb};
	endfunction

	// c*lim/s with the multiplier bits fed in msb first, digit 0..2
	function automatic logic [SUM_W+1:0] scl_step(input logic [SUM_W-1:0] rem,
			input logic [NUM_W-1:0] c, input logic [SUM_W-1:0] s, input logic b);
		logic [SUM_W+1:0] t;
		logic [SUM_W+1:0] s1;
		logic [SUM_W+1:0] s2;
		logic [SUM_W+1:0] r;
		logic [1:0]       d;
		t  = {rem, 1'b0} + (b ? {3'd0, c} : '0);
		s1 = {2'd0, s};
		s2 = {1'b0, s, 1'b0};
		if (t >= s2) begin
			r = t - s2;
			d = 2'd2;
		end else if (t >= s1) begin
			r = t - s1;
			d = 2'd1;
		end else begin
			r = t;
			d = 2'd0;
		end
		return {r[SUM_W-1:0], d};
	endfunction

endpackage
`default_nettype wire

### rtl/diff_drive_wheel_rpm.sv
// throughput: one command word per cycle while the pipeline has an empty slot;
//   stages advance into empty slots, so a result held at the output still lets earlier stages fill
// the three 40-step wheel dividers and the 18-step scaling dividers set the depth
// reset: arst_n clears all valid bits and loads the default configuration
`default_nettype none
module diff_drive_wheel_rpm (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// vel_x_mm_s, vel_y_mm_s, yaw_rate_mrad_s
	input  wire logic [47:0]                   s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// left_wheel_rpm_q8, right_wheel_rpm_q8, zero pad
	output logic [39:0]                        m_tdata,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ddwr_pkg::CIDX_W-1:0]   cfg_index,
	input  wire logic [ddwr_pkg::CIRC_W-1:0]   cfg_data
);
	import ddwr_pkg::*;

	logic [CIRC_W-1:0] circ_q;
	logic [TRK_W-1:0]  track_q;
	logic [MAX_W-1:0]  max_q;
	logic [CIRC_W-1:0] circ_eff;

	logic  d_valid, d_ready, s_valid, s_ready;
	comp_t d_c, s_c;
	logic [OUT_W-1:0] left, right;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_q  <= CIRC_W'(628319);
			track_q <= TRK_W'(380);
			max_q   <= MAX_W'(120);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CIRC:  circ_q  <= cfg_data;
				CFG_TRACK: track_q <= cfg_data[TRK_W-1:0];
				CFG_MAX:   max_q   <= cfg_data[MAX_W-1:0];
				default:   ;
			endcase
		end
	end

	// zero circumference runs as one micrometre
	assign circ_eff = (circ_q == '0) ? CIRC_W'(1) : circ_q;

	ddwr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_vx     (s_tdata[15:0]),
		.in_vy     (s_tdata[31:16]),
		.in_wz     (s_tdata[47:32]),
		.circ      (circ_eff),
		.track     (track_q),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out       (d_c)
	);

	ddwr_scl u_scl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.in_c      (d_c),
		.max_rpm   (max_q),
		.out_valid (s_valid),
		.out_ready (s_ready),
		.out       (s_c)
	);

	ddwr_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_valid),
		.in_ready  (s_ready),
		.in_c      (s_c),
		.max_rpm   (max_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_left  (left),
		.out_right (right)
	);

	assign m_tdata = {2'b00, right, left};

endmodule
`default_nettype wire

### rtl/ddwr_div.sv
`default_nettype none
module ddwr_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [ddwr_pkg::VEL_W-1:0]   in_vx,
	input  wire logic [ddwr_pkg::VEL_W-1:0]   in_vy,
	input  wire logic [ddwr_pkg::VEL_W-1:0]   in_wz,
	input  wire logic [ddwr_pkg::CIRC_W-1:0]  circ,
	input  wire logic [ddwr_pkg::TRK_W-1:0]   track,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output ddwr_pkg::comp_t                   out
);
	import ddwr_pkg::*;

	localparam int N = NUM_W;

	logic [N:0]        v_s;
	logic [N:0]        ld;
	logic [NUM_W-1:0]  nx_s [0:N];
	logic [NUM_W-1:0]  ny_s [0:N];
	logic [NUM_W-1:0]  nt_s [0:N];
	logic [CIRC_W-1:0] rx_s [0:N];
	logic [CIRC_W-1:0] ry_s [0:N];
	logic [CIRC_W-1:0] rt_s [0:N];
	flg_t              f_s  [0:N];

	logic [VEL_W-1:0]       mx, my, mw;
	logic [VEL_W+TRK_W-1:0] pt;

	always_comb begin
		ld[N] = !v_s[N] || out_ready;
		for (int i = N - 1; i >= 0; i--) begin
			ld[i] = !v_s[i] || ld[i+1];
		end
	end

	assign in_ready = ld[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (ld[0]) begin
				v_s[0] <= in_valid;
			end
			for (int i = 1; i <= N; i++) begin
				if (ld[i]) begin
					v_s[i] <= v_s[i-1];
				end
			end
		end
	end

	assign mx = mag16(in_vx);
	assign my = mag16(in_vy);
	assign mw = mag16(in_wz);
	assign pt = {{TRK_W{1'b0}}, mw} * {{VEL_W{1'b0}}, track};

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			nx_s[0]  <= {24'd0, mx} * {16'd0, XY_GAIN};
			ny_s[0]  <= {24'd0, my} * {16'd0, XY_GAIN};
			// times 7680
			nt_s[0]  <= ({12'd0, pt} << 13) - ({12'd0, pt} << 9);
			rx_s[0]  <= '0;
			ry_s[0]  <= '0;
			rt_s[0]  <= '0;
			f_s[0]   <= '{sx: in_vx[VEL_W-1], sy: in_vy[VEL_W-1], st: in_wz[VEL_W-1],
				lat: (in_vy != '0) && (in_wz == '0), yaw: (in_wz != '0) && (in_vy == '0)};
		end
	end

	for (genvar g = 1; g <= N; g++) begin : g_step
		always_ff @(posedge clk) begin
			if (ld[g]) begin
				{rx_s[g], nx_s[g]} <= div_step(rx_s[g-1], nx_s[g-1], circ);
				{ry_s[g], ny_s[g]} <= div_step(ry_s[g-1], ny_s[g-1], circ);
				{rt_s[g], nt_s[g]} <= div_step(rt_s[g-1], nt_s[g-1], circ);
				f_s[g] <= f_s[g-1];
			end
		end
	end

	assign out_valid = v_s[N];
	assign out       = '{ax: nx_s[N], ay: ny_s[N], at: nt_s[N], f: f_s[N]};

`ifndef ASSERT_OFF
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[N] |-> (rx_s[N] < circ) && (ry_s[N] < circ) && (rt_s[N] < circ))
		else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire

### rtl/ddwr_scl.sv
`default_nettype none
module ddwr_scl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire ddwr_pkg::comp_t             in_c,
	input  wire logic [ddwr_pkg::MAX_W-1:0]  max_rpm,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output ddwr_pkg::comp_t                  out
);
	import ddwr_pkg::*;

	localparam int N = SCL_N + 1;

	logic [N:0]       v_s;
	logic [N:0]       ld;
	comp_t            c_s  [0:N];
	logic [SUM_W-1:0] sm_s [0:N-1];
	logic [SUM_W-1:0] r1_s [0:N-1];
	logic [SUM_W-1:0] r2_s [0:N-1];
	logic [LIM_W-1:0] q1_s [0:N-1];
	logic [LIM_W-1:0] q2_s [0:N-1];
	logic [N-1:0]     en_s;

	logic [LIM_W-1:0] lim;
	logic [NUM_W-1:0] pb;
	logic [SUM_W-1:0] sum;
	logic [NUM_W-1:0] fb;
	comp_t            sc;

	assign lim = {max_rpm, 8'd0};
	assign pb  = in_c.f.lat ? in_c.ay : in_c.at;
	assign sum = {1'b0, in_c.ax} + {1'b0, pb};

	always_comb begin
		ld[N] = !v_s[N] || out_ready;
		for (int i = N - 1; i >= 0; i--) begin
			ld[i] = !v_s[i] || ld[i+1];
		end
	end

	assign in_ready = ld[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (ld[0]) begin
				v_s[0] <= in_valid;
			end
			for (int i = 1; i <= N; i++) begin
				if (ld[i]) begin
					v_s[i] <= v_s[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			c_s[0]  <= in_c;
			sm_s[0] <= sum;
			r1_s[0] <= '0;
			r2_s[0] <= '0;
			q1_s[0] <= '0;
			q2_s[0] <= '0;
			en_s[0] <= (in_c.f.lat || in_c.f.yaw) && (sum != '0)
				&& (sum >= {{(SUM_W-LIM_W){1'b0}}, lim});
		end
	end

	for (genvar g = 1; g < N; g++) begin : g_step
		localparam int K = g - 1;
		logic             b;
		logic [1:0]       d1, d2;
		logic [SUM_W-1:0] n1, n2;
		logic [NUM_W-1:0] cb;

		if (K < MAX_W) begin : g_bit
			assign b = max_rpm[MAX_W-1-K];
		end else begin : g_zero
			assign b = 1'b0;
		end

		assign cb = c_s[g-1].f.lat ? c_s[g-1].ay : c_s[g-1].at;
		assign {n1, d1} = scl_step(r1_s[g-1], c_s[g-1].ax, sm_s[g-1], b);
		assign {n2, d2} = scl_step(r2_s[g-1], cb, sm_s[g-1], b);

		always_ff @(posedge clk) begin
			if (ld[g]) begin
				c_s[g]  <= c_s[g-1];
				sm_s[g] <= sm_s[g-1];
				en_s[g] <= en_s[g-1];
				r1_s[g] <= n1;
				r2_s[g] <= n2;
				q1_s[g] <= {q1_s[g-1][LIM_W-2:0], 1'b0} + {{(LIM_W-2){1'b0}}, d1};
				q2_s[g] <= {q2_s[g-1][LIM_W-2:0], 1'b0} + {{(LIM_W-2){1'b0}}, d2};
			end
		end
	end

	assign fb = {{(NUM_W-LIM_W){1'b0}}, q2_s[N-1]};

	always_comb begin
		sc = c_s[N-1];
		if (en_s[N-1]) begin
			sc.ax = {{(NUM_W-LIM_W){1'b0}}, q1_s[N-1]};
			if (c_s[N-1].f.lat) begin
				sc.ay = fb;
			end else begin
				sc.at = fb;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[N]) begin
			c_s[N] <= sc;
		end
	end

	assign out_valid = v_s[N];
	assign out       = c_s[N];

`ifndef ASSERT_OFF
	a_scl_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[N-1] && en_s[N-1] |-> (r1_s[N-1] < sm_s[N-1]) && (r2_s[N-1] < sm_s[N-1]))
		else $error("scaling remainder not below sum");
	a_scl_sum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[N-1] && en_s[N-1] |->
			({1'b0, q1_s[N-1]} + {1'b0, q2_s[N-1]}) <= {1'b0, lim})
		else $error("scaled pair exceeds limit");
`endif

endmodule
`default_nettype wire

### rtl/ddwr_mix.sv
`default_nettype none
module ddwr_mix (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire ddwr_pkg::comp_t             in_c,
	input  wire logic [ddwr_pkg::MAX_W-1:0]  max_rpm,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [ddwr_pkg::OUT_W-1:0]       out_left,
	output logic [ddwr_pkg::OUT_W-1:0]       out_right
);
	import ddwr_pkg::*;

	logic [1:0]              v_s;
	logic [1:0]              ld;
	logic signed [MIX_W-1:0] m1_s1, m2_s1;
	logic [OUT_W-1:0]        l_s2, r_s2;
	logic signed [MIX_W-1:0] x, y, t, lim, nlim;

	function automatic logic signed [MIX_W-1:0] sgn(input logic s, input logic [NUM_W-1:0] m);
		logic signed [MIX_W-1:0] e;
		e = signed'({3'd0, m});
		return s ? -e : e;
	endfunction

	function automatic logic [OUT_W-1:0] clamp(input logic signed [MIX_W-1:0] m,
			input logic signed [MIX_W-1:0] hi, input logic signed [MIX_W-1:0] lo);
		logic signed [MIX_W-1:0] r;
		if (m > hi) begin
			r = hi;
		end else if (m < lo) begin
			r = lo;
		end else begin
			r = m;
		end
		return r[OUT_W-1:0];
	endfunction

	assign x    = sgn(in_c.f.sx, in_c.ax);
	assign y    = sgn(in_c.f.sy, in_c.ay);
	assign t    = sgn(in_c.f.st, in_c.at);
	assign lim  = signed'({{(MIX_W-LIM_W){1'b0}}, max_rpm, 8'd0});
	assign nlim = -lim;

	assign ld[1]    = !v_s[1] || out_ready;
	assign ld[0]    = !v_s[0] || ld[1];
	assign in_ready = ld[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (ld[0]) begin
				v_s[0] <= in_valid;
			end
			if (ld[1]) begin
				v_s[1] <= v_s[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			m1_s1 <= x - y - t;
			m2_s1 <= x + y + t;
		end
		if (ld[1]) begin
			l_s2 <= clamp(m1_s1, lim, nlim);
			r_s2 <= clamp(m2_s1, lim, nlim);
		end
	end

	assign out_valid = v_s[1];
	assign out_left  = l_s2;
	assign out_right = r_s2;

`ifndef ASSERT_OFF
	a_mix_rng: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[1] |-> (signed'(l_s2) <= signed'(lim[OUT_W-1:0]))
			&& (signed'(r_s2) <= signed'(lim[OUT_W-1:0])))
		else $error("wheel output above limit");
`endif

endmodule
`default_nettype wire

### bench/diff_drive_wheel_rpm_test.sv
`default_nettype none
module diff_drive_wheel_rpm_test;
	import ddwr_pkg::*;

	typedef struct packed {
		logic signed [18:0] right;
		logic signed [18:0] left;
	} wheel_pair_t;

	class wheel_scoreboard;
		wheel_pair_t pending[$];
		int errors;
		longint circ_um;
		longint track_mm;
		longint max_rpm;

		function new();
			errors = 0;
			circ_um = 628319;
			track_mm = 380;
			max_rpm = 120;
		endfunction

		function longint scale_div(longint v, longint mul, longint dv);
			longint q;
			q = ((v < 0 ? -v : v) * mul) / dv;
			return v < 0 ? -q : q;
		endfunction

		function longint clip(longint v, longint lim);
			if (v > lim)
				return lim;
			if (v < -lim)
				return -lim;
			return v;
		endfunction

		function void note_command(logic signed [15:0] vx, logic signed [15:0] vy,
				logic signed [15:0] wz);
			longint c, lim, x, y, t, s;
			wheel_pair_t r;
			c = circ_um == 0 ? 1 : circ_um;
			lim = max_rpm * 256;
			x = scale_div(longint'(vx), 60000 * 256, c);
			y = scale_div(longint'(vy), 60000 * 256, c);
			t = scale_div(longint'(wz) * track_mm, 30 * 256, c);
			if (vy != 0 && wz == 0) begin
				s = (x < 0 ? -x : x) + (y < 0 ? -y : y);
				if (s != 0 && s >= lim) begin
					x = scale_div(x, lim, s);
					y = scale_div(y, lim, s);
				end
			end
			if (wz != 0 && vy == 0) begin
				s = (x < 0 ? -x : x) + (t < 0 ? -t : t);
				if (s != 0 && s >= lim) begin
					x = scale_div(x, lim, s);
					t = scale_div(t, lim, s);
				end
			end
			r.left = 19'(clip(x - y - t, lim));
			r.right = 19'(clip(x + y + t, lim));
			pending.push_back(r);
		endfunction

		function void check_wheels(logic [39:0] d);
			wheel_pair_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected word %h", $time, d);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[18:0] !== e.left) begin
				$display("%0t left expected %0d actual %0d", $time, e.left,
					$signed(d[18:0]));
				errors++;
			end
			if (d[37:19] !== e.right) begin
				$display("%0t right expected %0d actual %0d", $time, e.right,
					$signed(d[37:19]));
				errors++;
			end
			if (d[39:38] !== 2'b00) begin
				$display("%0t pad expected 0 actual %b", $time, d[39:38]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [39:0] m_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CIRC_W-1:0] cfg_data = '0;
	logic sink_on = 0;
	longint cycles = 0;
	wheel_scoreboard sb;

	always #2 clk = ~clk;

	diff_drive_wheel_rpm u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("RESULT: ERROR");
			$finish;
		end
		if (m_tvalid && m_tready)
			sb.check_wheels(m_tdata);
	end

	// receiver: random stall per word
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_on) begin
				w = $urandom_range(0, 16);
				if ($urandom_range(0, 3) == 0)
					w = 0;
				m_tready <= 0;
				repeat (w) @(negedge clk);
				m_tready <= 1;
				do @(posedge clk); while (!m_tvalid);
			end
		end
	end

	// valid stays high after the word until the next gap or drain
	task automatic send_command(logic [15:0] vx, logic [15:0] vy, logic [15:0] wz,
			int gap);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {wz, vy, vx};
		do @(posedge clk); while (!s_tready);
		sb.note_command(vx, vy, wz);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val[CIRC_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CIRC: sb.circ_um = val & 32'h3fffff;
			CFG_TRACK: sb.track_mm = val & 32'hfff;
			default: sb.max_rpm = val & 32'h3ff;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_vel();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'h7fff;
			2: return 16'h8000;
			3: return 16'(int'($urandom_range(0, 400)) - 200);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_phase(int n);
		logic [15:0] vx, vy, wz;
		int g;
		for (int i = 0; i < n; i++) begin
			vx = pick_vel();
			vy = pick_vel();
			wz = pick_vel();
			case ($urandom_range(0, 3))
				0: vy = 0;
				1: wz = 0;
				default: ;
			endcase
			g = $urandom_range(0, 16);
			if (i % 100 < 30)
				g = 0;
			send_command(vx, vy, wz, g);
		end
	endtask

	initial begin
		int unsigned circs[6] = '{628319, 1000, 4000000, 0, 4194303, 150000};
		int unsigned tracks[6] = '{380, 1, 4000, 4095, 0, 200};
		int unsigned maxes[6] = '{120, 1, 1023, 0, 600, 50};
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		sink_on <= 1;
		// directed at reset settings
		send_command(16'h0000, 16'h0000, 16'h0000, 0);
		send_command(16'h7fff, 16'h0000, 16'h0000, 0);
		send_command(16'h8000, 16'h0000, 16'h0000, 0);
		send_command(16'h0064, 16'h0032, 16'h0000, 0);
		send_command(16'h7fff, 16'h8000, 16'h0000, 1);
		send_command(16'h0000, 16'h0000, 16'h7fff, 0);
		send_command(16'h8000, 16'h0000, 16'h8000, 2);
		send_command(16'h0064, 16'h0000, 16'h0064, 0);
		send_command(16'h7fff, 16'h7fff, 16'h7fff, 0);
		send_command(16'h8000, 16'h8000, 16'h8000, 0);
		send_command(16'hffff, 16'h0001, 16'hffff, 0);
		send_command(16'h5555, 16'haaaa, 16'h0000, 0);
		send_command(16'haaaa, 16'h0000, 16'h5555, 0);
		drain();
		random_phase(300);
		for (int p = 0; p < 6; p++) begin
			drain();
			write_reg(CFG_CIRC, circs[p]);
			write_reg(CFG_TRACK, tracks[p]);
			write_reg(CFG_MAX, maxes[p]);
			send_command(16'h7fff, 16'h0000, 16'h8000, 0);
			send_command(16'h0000, 16'h8000, 16'h0000, 0);
			random_phase(280);
		end
		drain();
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
